@@ design/plse_pkg.sv @@
// shared constants, command and register codes, and state type for the spin energy core
`timescale 1ns / 1ps

package plse_pkg;

    localparam int CMD_W      = 2;
    localparam int SITE_W     = 10;
    localparam int AXIS_W     = 2;
    localparam int DIST_W     = 2;
    localparam int VALUE_W    = 8;
    localparam int ENERGY_W   = 22;

    localparam int SIDE_W     = 11;
    localparam int DIMS_W     = 3;
    localparam int REACH_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_SITES = 1024;
    localparam int DEF_MAX_DIMS  = 4;
    localparam int DEF_MAX_REACH = 2;

    localparam logic [SIDE_W-1:0]  SIDE_RST  = 11'd16;
    localparam logic [DIMS_W-1:0]  DIMS_RST  = 3'd2;
    localparam logic [REACH_W-1:0] REACH_RST = 2'd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_COUPLING = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPIN     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REACH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_AXIS,
        ST_EDGE,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

@@ design/periodic_lattice_spin_energy_core.sv @@
// spin energy core: coupling and spin stores with a walker over a periodic lattice
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid / in_stall) carries one command per beat: write a
// coupling for a site, axis and distance, write a spin bit, or evaluate the energy.
// Writes complete in the cycle the beat is taken and produce no result beat.
// An evaluate produces one beat on the output channel (out_valid / out_stall)
// with the saturated energy and a size error flag for an unusable geometry.
// Evaluate walks n = side^dims sites with r the clipped reach: the geometry
// check steps through the axes one at a time, then each site and axis is loaded
// and the coupling memory is read once per distance, bound by its single read
// port; a bad geometry answers without the walk. in_stall stays high from an
// evaluate until its result is in the output
// register. The output register holds a result while out_stall is high, and
// writes are still taken meanwhile; a second evaluate then waits for the
// register to free. Reset returns side, dims and reach to 16, 2 and 1 and
// empties the output; the coupling and spin memories hold nothing meaningful
// until written and need no clearing pass.
module periodic_lattice_spin_energy_core #(
    parameter int MAX_SITES = plse_pkg::DEF_MAX_SITES,
    parameter int MAX_DIMS  = plse_pkg::DEF_MAX_DIMS,
    parameter int MAX_REACH = plse_pkg::DEF_MAX_REACH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [plse_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [plse_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [plse_pkg::CMD_W-1:0]             cmd,
    input  logic [plse_pkg::SITE_W-1:0]            site,
    input  logic [plse_pkg::AXIS_W-1:0]            axis,
    input  logic [plse_pkg::DIST_W-1:0]            distance,
    input  logic signed [plse_pkg::VALUE_W-1:0]    value,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [plse_pkg::ENERGY_W-1:0]   energy,
    output logic                                   size_error
);

    import plse_pkg::*;

    localparam int SW     = $clog2(MAX_SITES);
    localparam int NW     = $clog2(MAX_SITES + 1);
    localparam int AW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ADEPTH = 1 << AW;
    localparam int DW     = (MAX_REACH > 1) ? $clog2(MAX_REACH) : 1;
    localparam int RW     = $clog2(MAX_REACH + 1);
    localparam int CAW    = SW + AW + DW;
    localparam int CDEPTH = 1 << CAW;
    localparam int XW     = ((SW > SIDE_W) ? SW : SIDE_W) + 1;
    localparam int PW     = NW + SIDE_W;
    localparam int DCW    = ((AW > DIMS_W) ? AW : DIMS_W) + 1;
    localparam int RCW    = ((RW > REACH_W) ? RW : REACH_W) + 1;
    localparam int SUMW   = $clog2(MAX_SITES * MAX_DIMS * MAX_REACH) + VALUE_W + 1;
    localparam int CMPW   = (SUMW > ENERGY_W) ? SUMW : ENERGY_W;
    localparam int SXW    = (SW > SITE_W) ? SW : SITE_W;
    localparam int AXW    = (AW > AXIS_W) ? AW : AXIS_W;

    // configuration
    logic [SIDE_W-1:0]  side_reg;
    logic [DIMS_W-1:0]  dims_reg;
    logic [REACH_W-1:0] reach_reg;

    state_t state_reg, state_next;

    // walker
    logic [NW-1:0]  n_reg;
    logic [RW-1:0]  r_reg;
    logic           err_reg;
    logic [SW-1:0]  s_reg;
    logic [AW-1:0]  a_reg;
    logic [RW-1:0]  d_reg;
    logic [SW-1:0]  nc_reg, nc_next;
    logic [SW-1:0]  nb_reg, nb_next;
    logic [SW-1:0]  stride_reg [ADEPTH];
    logic [SW-1:0]  dig_reg    [ADEPTH];
    logic [SW-1:0]  off_reg    [ADEPTH];
    logic [SW-1:0]  dig_next   [ADEPTH];
    logic [SW-1:0]  off_next   [ADEPTH];

    // read and accumulate pipeline
    logic                      p1_valid_reg;
    logic [SW-1:0]             p1_s_reg;
    logic [SW-1:0]             p1_nb_reg;
    logic [CAW-1:0]            p1_caddr_reg;
    logic                      p2_valid_reg;
    logic signed [VALUE_W-1:0] coup_rd_reg;
    logic                      spin_self_reg;
    logic                      spin_nb_reg;
    logic signed [SUMW-1:0]    sum_reg;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic                       size_error_reg;

    logic [VALUE_W-1:0] coup_mem [CDEPTH];
    logic               spin_mem [MAX_SITES];

    // decoded controls
    logic in_accept;
    logic coup_we;
    logic spin_we;
    logic eval_start;
    logic edge_issue;
    logic load_out;

    logic               site_ok, axis_ok, dist_ok;
    logic [SXW-1:0]     site_x;
    logic [AXW-1:0]     axis_x;
    logic [DIST_W-1:0]  dist_m1;
    logic [SW-1:0]      site_idx;
    logic [CAW-1:0]     wr_caddr;

    logic               bad_geom;
    logic [RW-1:0]      r_clip;
    logic [PW-1:0]      prod;
    logic               prod_over;
    logic               a_last, d_last, s_last, nc_wrap, out_free;

    logic signed [SUMW-1:0] term;
    logic signed [CMPW-1:0] sum_x, emax_x, emin_x, sat_x;

    // ---------------- input decode ----------------
    assign in_accept = in_valid && !in_stall;
    assign site_ok   = 32'(site) < 32'(MAX_SITES);
    assign axis_ok   = 32'(axis) < 32'(MAX_DIMS);
    assign dist_ok   = (distance != '0) && (32'(distance) <= 32'(MAX_REACH));
    assign site_x    = SXW'(site);
    assign axis_x    = AXW'(axis);
    assign dist_m1   = distance - DIST_W'(1);
    assign site_idx  = site_x[SW-1:0];
    assign wr_caddr  = {site_idx, axis_x[AW-1:0], dist_m1[DW-1:0]};

    // ---------------- geometry and loop bounds ----------------
    assign bad_geom  = (side_reg == '0) || (dims_reg == '0) || (32'(dims_reg) > 32'(MAX_DIMS));
    assign r_clip    = (32'(reach_reg) > 32'(MAX_REACH)) ? RW'(MAX_REACH) : RW'(reach_reg);
    assign prod      = PW'(n_reg) * PW'(side_reg);
    assign prod_over = prod > PW'(MAX_SITES);
    assign a_last    = (DCW'(a_reg) + DCW'(1)) == DCW'(dims_reg);
    assign d_last    = (RCW'(d_reg) + RCW'(1)) == RCW'(r_reg);
    assign s_last    = ((NW + 1)'(s_reg) + (NW + 1)'(1)) == (NW + 1)'(n_reg);
    assign nc_wrap   = (XW'(nc_reg) + XW'(1)) == XW'(side_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    // step to the next forward neighbour along the current axis
    always_comb
    begin
        if (nc_wrap)
        begin
            nc_next = '0;
            nb_next = s_reg - off_reg[a_reg];
        end
        else
        begin
            nc_next = nc_reg + SW'(1);
            nb_next = nb_reg + stride_reg[a_reg];
        end
    end

    // mixed radix increment of the site coordinates
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int k = 0; k < ADEPTH; k++)
        begin
            dig_next[k] = dig_reg[k];
            off_next[k] = off_reg[k];
            if (carry)
            begin
                if ((XW'(dig_reg[k]) + XW'(1)) == XW'(side_reg))
                begin
                    dig_next[k] = '0;
                    off_next[k] = '0;
                end
                else
                begin
                    dig_next[k] = dig_reg[k] + SW'(1);
                    off_next[k] = off_reg[k] + stride_reg[k];
                    carry       = 1'b0;
                end
            end
        end
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && cmd == CMD_EVAL)
                begin
                    state_next = bad_geom ? ST_DONE : ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (prod_over)
                begin
                    state_next = ST_DONE;
                end
                else if (a_last)
                begin
                    state_next = (r_reg == '0) ? ST_DONE : ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (d_last && a_last && s_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (d_last)
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        coup_we    = 1'b0;
        spin_we    = 1'b0;
        eval_start = 1'b0;
        edge_issue = (state_reg == ST_EDGE);
        load_out   = (state_reg == ST_DONE) && out_free;
        if (state_reg == ST_IDLE && in_accept)
        begin
            unique case (cmd)
                CMD_COUPLING: coup_we    = site_ok && axis_ok && dist_ok;
                CMD_SPIN:     spin_we    = site_ok;
                CMD_EVAL:     eval_start = 1'b1;
                default:      ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= SIDE_RST;
            dims_reg      <= DIMS_RST;
            reach_reg     <= REACH_RST;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= edge_issue;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIDE:  side_reg  <= cfg_data;
                    REG_DIMS:  dims_reg  <= cfg_data[DIMS_W-1:0];
                    REG_REACH: reach_reg <= cfg_data[REACH_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    // ---------------- walker datapath ----------------
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            err_reg <= bad_geom;
            n_reg   <= NW'(1);
            a_reg   <= '0;
            r_reg   <= r_clip;
        end

        if (state_reg == ST_SIZE)
        begin
            stride_reg[a_reg] <= n_reg[SW-1:0];
            if (prod_over)
            begin
                err_reg <= 1'b1;
            end
            else
            begin
                n_reg <= prod[NW-1:0];
                if (a_last)
                begin
                    a_reg <= '0;
                    s_reg <= '0;
                    for (int k = 0; k < ADEPTH; k++)
                    begin
                        dig_reg[k] <= '0;
                        off_reg[k] <= '0;
                    end
                end
                else
                begin
                    a_reg <= a_reg + AW'(1);
                end
            end
        end

        if (state_reg == ST_AXIS)
        begin
            nc_reg <= dig_reg[a_reg];
            nb_reg <= s_reg;
            d_reg  <= '0;
        end

        if (edge_issue)
        begin
            nc_reg       <= nc_next;
            nb_reg       <= nb_next;
            d_reg        <= d_reg + RW'(1);
            p1_s_reg     <= s_reg;
            p1_nb_reg    <= nb_next;
            p1_caddr_reg <= {s_reg, a_reg, d_reg[DW-1:0]};
            if (d_last)
            begin
                if (!a_last)
                begin
                    a_reg <= a_reg + AW'(1);
                end
                else if (!s_last)
                begin
                    a_reg <= '0;
                    s_reg <= s_reg + SW'(1);
                    for (int k = 0; k < ADEPTH; k++)
                    begin
                        dig_reg[k] <= dig_next[k];
                        off_reg[k] <= off_next[k];
                    end
                end
            end
        end

        if (eval_start)
        begin
            sum_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            sum_reg <= sum_reg + term;
        end

        if (load_out)
        begin
            energy_reg     <= sat_x[ENERGY_W-1:0];
            size_error_reg <= err_reg;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (coup_we)
        begin
            coup_mem[wr_caddr] <= value;
        end
        coup_rd_reg <= coup_mem[p1_caddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (spin_we)
        begin
            spin_mem[site_idx] <= value[0];
        end
        spin_self_reg <= spin_mem[p1_s_reg];
        spin_nb_reg   <= spin_mem[p1_nb_reg];
    end

    // equal spins add the coupling, unequal spins subtract it
    always_comb
    begin
        term = SUMW'(coup_rd_reg);
        if (spin_self_reg != spin_nb_reg)
        begin
            term = -term;
        end
    end

    assign sum_x  = CMPW'(sum_reg);
    assign emax_x = {{(CMPW - ENERGY_W + 1){1'b0}}, {(ENERGY_W - 1){1'b1}}};
    assign emin_x = {{(CMPW - ENERGY_W + 1){1'b1}}, {(ENERGY_W - 1){1'b0}}};

    always_comb
    begin
        priority if (sum_x > emax_x)
        begin
            sat_x = emax_x;
        end
        else if (sum_x < emin_x)
        begin
            sat_x = emin_x;
        end
        else
        begin
            sat_x = sum_x;
        end
    end

    assign out_valid  = out_valid_reg;
    assign energy     = energy_reg;
    assign size_error = size_error_reg;

    // ---------------- assertions ----------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("new beat taken while edge reads still in flight");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_site_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AXIS || state_reg == ST_EDGE) |-> (NW'(s_reg) < n_reg))
        else $error("walker site beyond lattice size");

    a_error_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && size_error_reg) |-> (energy_reg == '0))
        else $error("size error with nonzero energy");

endmodule
